### src/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg: shared types and constants for the ordered list engine
// Holds the list size, field widths, request and status codes, and the
// per-cell shift operation used between the control logic and the cell row.
// ----------------------------------------------------------------------------
package olist_pkg;

  // List size and word width
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned WORD_BITS = 32;

  // Field widths fixed by the interface
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);

  // Request kinds; the one unused code is ignored by the engine
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT_AT  = 3'd4,
    KIND_DELETE_AT  = 3'd5,
    KIND_READ_AT    = 3'd6
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // What one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,  // take the word of the cell one index lower
    CELL_SHIFT_DOWN = 2'd3   // take the word of the cell one index higher
  } cell_op_e;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

### src/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell: one storage slot of the ordered list
// Holds one data word and, on command, keeps it, loads a new word, or takes
// the word of either neighbor so the whole row shifts at once.
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                clk_i,
  input  olist_pkg::cell_op_e op_i,
  input  olist_pkg::word_t    lower_i,
  input  olist_pkg::word_t    upper_i,
  input  olist_pkg::word_t    load_i,
  output olist_pkg::word_t    word_o
);
  import olist_pkg::*;

  word_t word_d, word_q;

  // Next-word select
  always_comb begin
    case (op_i)
      CELL_HOLD:       word_d = word_q;
      CELL_LOAD:       word_d = load_i;
      CELL_SHIFT_UP:   word_d = lower_i;
      CELL_SHIFT_DOWN: word_d = upper_i;
      default:         word_d = word_q;
    endcase
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

### src/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top: bounded ordered list with indexed insert/delete
// A row of cells holds the list, front at index 0; insert and delete shift
// every affected cell at once.
// ----------------------------------------------------------------------------
// Usage: a request is taken at each rising edge with start_i high and busy_o
// low. busy_o never rises: every request is handled at once because
// all cells of the row shift in parallel, so one request per clock is
// sustained. The result (status_o, word_out_o, count_o) appears one cycle
// after the request, marked by a one-cycle done_o strobe, and must be
// captured then; the receiver cannot stall. No clearing pass runs after
// reset: the list starts empty and only entries below the count are read.
// ----------------------------------------------------------------------------
module ordered_list_engine_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [olist_pkg::KIND_W-1:0]      kind_i,
  input  logic [olist_pkg::POS_W-1:0]       position_i,
  input  logic [31:0]                       word_in_i,
  output logic                              done_o,
  output logic [olist_pkg::STATUS_W-1:0]    status_o,
  output logic [31:0]                       word_out_o,
  output logic [olist_pkg::CNT_W-1:0]       count_o
);
  import olist_pkg::*;

  logic                 done_q;
  status_e              status_d, status_q;
  word_t                word_d, word_q;
  logic [CNT_W-1:0]     count_d, count_q;

  logic [POS_W-1:0]     eff_pos;
  logic                 ins_ok, del_ok;
  word_t                word_in;
  word_t                cell_word [CAPACITY];
  cell_op_e             cell_op   [CAPACITY];

  assign word_in = word_in_i[WORD_BITS-1:0];
  assign busy_o  = 1'b0;

  // Effective index of the request
  always_comb begin
    case (kind_i)
      KIND_PUSH_FRONT, KIND_POP_FRONT: eff_pos = '0;
      KIND_PUSH_BACK:                  eff_pos = POS_W'(count_q);
      KIND_POP_BACK:                   eff_pos = POS_W'(count_q - CNT_W'(1));
      default:                         eff_pos = position_i;
    endcase
  end

  // Checks, read-out word and new count
  always_comb begin
    status_d = ST_OK;
    word_d   = '0;
    count_d  = count_q;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    case (kind_i)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
        if (eff_pos > POS_W'(count_q)) begin
          status_d = ST_RANGE;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK, KIND_DELETE_AT, KIND_READ_AT: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (eff_pos >= POS_W'(count_q)) begin
          status_d = ST_RANGE;
        end else begin
          word_d = cell_word[eff_pos[IDX_W-1:0]];
          if (kind_i != KIND_READ_AT) begin
            del_ok  = 1'b1;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      default: ;  // unused code: ignored
    endcase
  end

  // Cell row: each cell shifts, loads or holds according to its index
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t lower_w, upper_w;

    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_lower
      assign lower_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_upper
      assign upper_w = cell_word[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (start_i && ins_ok) begin
        if (POS_W'(i) == eff_pos) begin
          cell_op[i] = CELL_LOAD;
        end else if (POS_W'(i) > eff_pos) begin
          cell_op[i] = CELL_SHIFT_UP;
        end
      end else if (start_i && del_ok && (POS_W'(i) >= eff_pos)) begin
        cell_op[i] = CELL_SHIFT_DOWN;
      end
    end

    olist_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .load_i  (word_in),
      .word_o  (cell_word[i])
    );
  end

  // Control state: strobe and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= start_i;
      if (start_i) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload of the transaction
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      status_q <= status_d;
      word_q   <= word_d;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign word_out_o = 32'(word_q);
  assign count_o    = count_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_o)
    else $error("transaction without result strobe");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> $stable(count_o))
    else $error("failed transaction changed the count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_o == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule

### bench/tb_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top: self-checking bench for the ordered list engine
// Drives push, pop, indexed insert, delete and read requests, directed, then
// in random bursts, keeps a shadow list to predict every result, and compares
// each strobed result field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
  import olist_pkg::*;

  typedef logic [CNT_W-1:0] count_t;

  // One predicted result
  typedef struct packed {
    status_e status;
    word_t   word;
    count_t  count;
  } list_outcome_t;

  // Shadow list plus the queue of results still owed by the engine
  class list_scoreboard;
    word_t         cells[CAPACITY];
    int unsigned   fill;
    int unsigned   peak;
    int unsigned   errors;
    int unsigned   ignored;
    int unsigned   tally[4];
    list_outcome_t owed_q[$];

    function new();
      fill    = 0;
      peak    = 0;
      errors  = 0;
      ignored = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its result
    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos, word_t w);
      list_outcome_t o;
      int unsigned   at;
      o.status = ST_OK;
      o.word   = '0;
      at       = pos;
      case (kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
          if (kind == KIND_PUSH_FRONT) at = 0;
          else if (kind == KIND_PUSH_BACK) at = fill;
          // range check wins over the full check
          if (at > fill) o.status = ST_RANGE;
          else if (fill >= CAPACITY) o.status = ST_FULL;
          else begin
            for (int i = fill; i > at; i--) cells[i] = cells[i-1];
            cells[at] = w;
            fill++;
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK, KIND_DELETE_AT, KIND_READ_AT: begin
          if (fill == 0) o.status = ST_EMPTY;
          else begin
            if (kind == KIND_POP_FRONT) at = 0;
            else if (kind == KIND_POP_BACK) at = fill - 1;
            if (at >= fill) o.status = ST_RANGE;
            else begin
              o.word = cells[at];
              if (kind != KIND_READ_AT) begin
                for (int i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
                fill--;
              end
            end
          end
        end
        default: ignored++;   // unused code: no change, still answered
      endcase
      o.count = count_t'(fill);
      if (fill > peak) peak = fill;
      tally[o.status]++;
      owed_q.push_back(o);
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_result(logic [STATUS_W-1:0] st, word_t w, count_t cnt);
      list_outcome_t o;
      if (owed_q.size() == 0) begin
        $display("%0t: result with no request outstanding: status %0d word %h count %0d",
                 $time, st, w, cnt);
        errors++;
        return;
      end
      o = owed_q.pop_front();
      if (st !== o.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, o.status, st);
        errors++;
      end
      if (w !== o.word) begin
        $display("%0t: word_out mismatch, expected %h, got %h", $time, o.word, w);
        errors++;
      end
      if (cnt !== o.count) begin
        $display("%0t: count mismatch, expected %0d, got %0d", $time, o.count, cnt);
        errors++;
      end
    endfunction
  endclass

  localparam logic [KIND_W-1:0] KIND_UNUSED  = 3'd7;
  localparam int unsigned       RANDOM_ITEMS = 1100;
  localparam int unsigned       LIMIT_CYCLES = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [KIND_W-1:0]   kind_i;
  logic [POS_W-1:0]    position_i;
  logic [31:0]         word_in_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [31:0]         word_out_o;
  logic [CNT_W-1:0]    count_o;

  list_scoreboard sb = new();
  int unsigned    taken  = 0;
  int unsigned    cycles = 0;

  ordered_list_engine_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .position_i (position_i),
    .word_in_i  (word_in_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .word_out_o (word_out_o),
    .count_o    (count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Check strobed results, then record the transaction taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, word_out_o, count_o);
      if (start_i && !busy_o) begin
        sb.note_request(kind_i, position_i, word_in_i);
        taken++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request at a falling edge and hold it until it is taken
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input word_t w);
    int unsigned goal;
    goal = taken + 1;
    start_i    <= 1'b1;
    kind_i     <= kind;
    position_i <= pos;
    word_in_i  <= w;
    while (taken < goal) @(negedge clk_i);
  endtask

  // Sender gap; the payload wanders while start is low
  task automatic idle_sender(input int unsigned n);
    start_i    <= 1'b0;
    kind_i     <= KIND_W'($urandom);
    position_i <= POS_W'($urandom);
    word_in_i  <= $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return POS_W'($urandom_range(0, sb.fill));
    if (r < 92) return POS_W'($urandom_range(0, CAPACITY));
    return POS_W'($urandom_range(CAPACITY + 1, 31));
  endfunction

  function automatic word_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // Weighted request mix: growing favors pushes, shrinking favors removals
  function automatic logic [KIND_W-1:0] pick_kind(input bit growing);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return KIND_UNUSED;
    if (growing) begin
      if (r < 22) return KIND_PUSH_FRONT;
      if (r < 42) return KIND_PUSH_BACK;
      if (r < 65) return KIND_INSERT_AT;
      if (r < 70) return KIND_POP_FRONT;
      if (r < 75) return KIND_POP_BACK;
      if (r < 85) return KIND_DELETE_AT;
      return KIND_READ_AT;
    end
    if (r < 8) return KIND_PUSH_FRONT;
    if (r < 13) return KIND_PUSH_BACK;
    if (r < 23) return KIND_INSERT_AT;
    if (r < 43) return KIND_POP_FRONT;
    if (r < 63) return KIND_POP_BACK;
    if (r < 83) return KIND_DELETE_AT;
    return KIND_READ_AT;
  endfunction

  initial begin
    int unsigned         sent;
    int unsigned         burst;
    bit                  growing;
    bit                  paused;
    logic [KIND_W-1:0]   k;

    rst_ni     = 1'b0;
    start_i    = 1'b0;
    kind_i     = '0;
    position_i = '0;
    word_in_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty list, range before full, ends and middle, full list
    send_request(KIND_POP_FRONT, POS_W'(0), '0);
    send_request(KIND_DELETE_AT, POS_W'(0), '0);
    send_request(KIND_READ_AT, POS_W'(0), '0);
    send_request(KIND_INSERT_AT, POS_W'(1), 32'h1111_1111);
    send_request(KIND_INSERT_AT, POS_W'(0), 32'h0000_0000);
    send_request(KIND_PUSH_BACK, POS_W'(0), 32'hFFFF_FFFF);
    send_request(KIND_PUSH_FRONT, POS_W'(0), 32'hA5A5_A5A5);
    send_request(KIND_INSERT_AT, POS_W'(3), 32'h1234_5678);
    send_request(KIND_INSERT_AT, POS_W'(2), 32'h5A5A_5A5A);
    send_request(KIND_READ_AT, POS_W'(4), '0);
    send_request(KIND_READ_AT, POS_W'(5), '0);
    send_request(KIND_DELETE_AT, POS_W'(31), '0);
    send_request(KIND_DELETE_AT, POS_W'(2), '0);
    send_request(KIND_UNUSED, POS_W'(5), 32'hDEAD_BEEF);
    while (sb.fill < CAPACITY)
      send_request(KIND_INSERT_AT, POS_W'(pick_position() % (sb.fill + 1)), pick_word());
    send_request(KIND_INSERT_AT, POS_W'(CAPACITY + 1), 32'h2222_2222);
    send_request(KIND_INSERT_AT, POS_W'(CAPACITY), 32'h3333_3333);
    send_request(KIND_PUSH_FRONT, POS_W'(0), 32'h4444_4444);
    send_request(KIND_READ_AT, POS_W'(CAPACITY - 1), '0);
    send_request(KIND_POP_BACK, POS_W'(0), '0);
    send_request(KIND_POP_FRONT, POS_W'(0), '0);
    drain_results();

    // Random bursts with random gaps
    sent    = 0;
    growing = 1'b1;
    paused  = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sb.fill == CAPACITY) growing = 1'b0;
        else if (sb.fill == 0) growing = 1'b1;
        else if ($urandom_range(0, 49) == 0) growing = ~growing;
        k = pick_kind(growing);
        send_request(k, pick_position(), pick_word());
        if (k != KIND_UNUSED) sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end

    idle_sender(1);
    drain_results();
    repeat (4) @(negedge clk_i);

    $display("covered %0d requests: %0d ok, %0d empty, %0d full, %0d out of range",
             taken, sb.tally[ST_OK], sb.tally[ST_EMPTY], sb.tally[ST_FULL], sb.tally[ST_RANGE]);
    $display("list reached %0d entries; %0d unused-code requests; %0d errors",
             sb.peak, sb.ignored, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
